/* rtl/bgt_pkg.sv */
package bgt_pkg;

	// Register field widths.
	localparam int LEN_W = 23;
	localparam int DIV_W = 9;
	localparam int OUT_W = 24;
	localparam int APB_DW = 32;
	localparam int APB_AW = 4;

	// Register reset values.
	localparam int BOX_LENGTH_RST = 65536;
	localparam int BOX_WIDTH_RST = 32768;
	localparam int ROWS_RST = 10;
	localparam int COLS_RST = 10;

	// Default values of the top level parameters.
	localparam int MAX_DIVISIONS_DEF = 256;
	localparam int COORD_BITS_DEF = 24;

	// Vertices emitted for one cell.
	localparam int VERTS = 12;
	localparam int VERT_W = 4;

	// Register map, indexed by paddr[3:2].
	typedef enum logic [1:0] {
		REG_BOX_LENGTH = 2'd0,
		REG_BOX_WIDTH  = 2'd1,
		REG_ROWS       = 2'd2,
		REG_COLS       = 2'd3
	} reg_idx_t;

	// Face pair currently being tessellated.
	typedef enum logic [1:0] {
		PH_BACK_FRONT = 2'd0,
		PH_TOP_BOTTOM = 2'd1,
		PH_LEFT_RIGHT = 2'd2
	} phase_t;

	// Corner selectors: bit 2 picks high x, bit 1 high y, bit 0 high z.
	localparam logic [2:0] CORNER_BF [VERTS] = '{
		3'd0, 3'd4, 3'd6, 3'd0, 3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd1, 3'd7, 3'd3};
	localparam logic [2:0] CORNER_TB [VERTS] = '{
		3'd0, 3'd4, 3'd5, 3'd0, 3'd5, 3'd1, 3'd2, 3'd6, 3'd7, 3'd2, 3'd7, 3'd3};
	localparam logic [2:0] CORNER_LR [VERTS] = '{
		3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd4, 3'd7, 3'd6};

	// Corner selector of vertex k on the given face pair.
	function automatic logic [2:0] corner_sel(phase_t ph, logic [VERT_W-1:0] k);
		logic [2:0] c;
		c = 3'd0;
		if (k < VERT_W'(VERTS)) begin
			case (ph)
				PH_BACK_FRONT: c = CORNER_BF[k];
				PH_TOP_BOTTOM: c = CORNER_TB[k];
				default:       c = CORNER_LR[k];
			endcase
		end
		return c;
	endfunction

endpackage

/* rtl/bgt_ifs.sv */
// Request channel: one restart-or-advance request per transfer.
interface bgt_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// Vertex channel: one vertex per transfer.
interface bgt_vtx_if;
	logic                              valid;
	logic                              ready;
	logic signed [bgt_pkg::OUT_W-1:0]  vx;
	logic signed [bgt_pkg::OUT_W-1:0]  vy;
	logic signed [bgt_pkg::OUT_W-1:0]  vz;
	logic                              cell_end;
	logic                              box_end;

	modport source (output valid, output vx, output vy, output vz, output cell_end,
		output box_end, input ready);
	modport sink (input valid, input vx, input vy, input vz, input cell_end,
		input box_end, output ready);
endinterface

/* rtl/box_grid_tessellator_core.sv */
// A request is accepted only while idle. The shared one-bit-per-cycle restoring divider then
// forms both grid steps in turn, a setup state follows, and the 12 vertices leave one per
// cycle while the sink is ready. The next request is accepted once the last vertex is taken.
// A request after the last cell without restart is accepted but produces nothing.
// arst_n clears all control state and loads the register reset values; the block is ready at once.
module box_grid_tessellator_core #(
	parameter int MAX_DIVISIONS = bgt_pkg::MAX_DIVISIONS_DEF,
	parameter int COORD_BITS = bgt_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bgt_pkg::APB_AW-1:0]   paddr,
	input  logic [bgt_pkg::APB_DW-1:0]   pwdata,
	output logic [bgt_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	bgt_req_if.sink                      req,
	bgt_vtx_if.source                    vtx
);

	localparam int CW = COORD_BITS;
	localparam int LEN_W = bgt_pkg::LEN_W;
	localparam int DIV_W = bgt_pkg::DIV_W;
	localparam int DIV_MAX = (1 << DIV_W) - 1;
	localparam int EFF_MAX = (MAX_DIVISIONS < DIV_MAX) ? MAX_DIVISIONS : DIV_MAX;
	localparam int CNT_W = $clog2(EFF_MAX + 1);
	localparam int STEP_W = $clog2(LEN_W);
	localparam logic [CW-1:0] OUTER_RST = CW'(-(bgt_pkg::BOX_WIDTH_RST / 2));
	localparam logic [CW-1:0] INNER_RST = CW'(-(bgt_pkg::BOX_LENGTH_RST / 2));

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV_V = 5'b00010,
		ST_DIV_H = 5'b00100,
		ST_SETUP = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [LEN_W-1:0]       box_length_q;
	logic [LEN_W-1:0]       box_width_q;
	logic [DIV_W-1:0]       rows_q;
	logic [DIV_W-1:0]       cols_q;

	bgt_pkg::phase_t        phase_q;
	logic [CNT_W-1:0]       row_q;
	logic [CNT_W-1:0]       col_q;
	logic [CW-1:0]          outer_q;
	logic [CW-1:0]          inner_q;
	logic                   finished_q;

	logic [bgt_pkg::VERT_W-1:0] vert_q;
	logic [STEP_W-1:0]      step_q;
	logic [LEN_W-1:0]       dq_q;
	logic [CNT_W-1:0]       rem_q;
	logic [CW-1:0]          vr_q;
	logic [CW-1:0]          hr_q;
	logic [CW-1:0]          lo_q [3];
	logic [CW-1:0]          hi_q [3];
	logic                   last_q;

	logic [CNT_W-1:0]       nr;
	logic [CNT_W-1:0]       nc;
	logic [CW-1:0]          hl;
	logic [CW-1:0]          hw;
	logic [CW-1:0]          neg_hl;
	logic [CW-1:0]          neg_hw;
	logic                   wr_en;
	bgt_pkg::reg_idx_t      wr_idx;
	logic                   req_acc;
	logic                   vtx_acc;
	logic                   last_vert;

	logic [CNT_W-1:0]       divisor;
	logic [CNT_W:0]         trial;
	logic [CNT_W:0]         diff;
	logic                   q_bit;
	logic [LEN_W-1:0]       dq_next;
	logic [CNT_W-1:0]       rem_next;
	logic                   div_done;

	logic [CNT_W-1:0]       col_inc;
	logic [CNT_W-1:0]       row_inc;
	logic [2:0]             corner;
	logic [CW-1:0]          sel_x;
	logic [CW-1:0]          sel_y;
	logic [CW-1:0]          sel_z;

	// Effective division counts: zero counts as one, large counts saturate.
	always_comb begin
		if (rows_q == '0) begin
			nr = CNT_W'(1);
		end else if (32'(rows_q) > MAX_DIVISIONS) begin
			nr = CNT_W'(EFF_MAX);
		end else begin
			nr = CNT_W'(rows_q);
		end
		if (cols_q == '0) begin
			nc = CNT_W'(1);
		end else if (32'(cols_q) > MAX_DIVISIONS) begin
			nc = CNT_W'(EFF_MAX);
		end else begin
			nc = CNT_W'(cols_q);
		end
	end

	// Half extents and their negations, wrapped to the coordinate width.
	assign hl = CW'(box_length_q >> 1);
	assign hw = CW'(box_width_q >> 1);
	assign neg_hl = CW'(0) - hl;
	assign neg_hw = CW'(0) - hw;

	// Configuration port.
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign wr_idx = bgt_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (bgt_pkg::reg_idx_t'(paddr[3:2]))
			bgt_pkg::REG_BOX_LENGTH: prdata = bgt_pkg::APB_DW'(box_length_q);
			bgt_pkg::REG_BOX_WIDTH:  prdata = bgt_pkg::APB_DW'(box_width_q);
			bgt_pkg::REG_ROWS:       prdata = bgt_pkg::APB_DW'(rows_q);
			bgt_pkg::REG_COLS:       prdata = bgt_pkg::APB_DW'(cols_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_length_q <= LEN_W'(bgt_pkg::BOX_LENGTH_RST);
			box_width_q <= LEN_W'(bgt_pkg::BOX_WIDTH_RST);
			rows_q <= DIV_W'(bgt_pkg::ROWS_RST);
			cols_q <= DIV_W'(bgt_pkg::COLS_RST);
		end else if (wr_en) begin
			unique case (wr_idx)
				bgt_pkg::REG_BOX_LENGTH: box_length_q <= pwdata[LEN_W-1:0];
				bgt_pkg::REG_BOX_WIDTH:  box_width_q <= pwdata[LEN_W-1:0];
				bgt_pkg::REG_ROWS:       rows_q <= pwdata[DIV_W-1:0];
				bgt_pkg::REG_COLS:       cols_q <= pwdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshakes.
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc = req.valid & req.ready;
	assign vtx_acc = vtx.valid & vtx.ready;
	assign last_vert = (vert_q == bgt_pkg::VERT_W'(bgt_pkg::VERTS - 1));

	// Shared restoring divider: one quotient bit per cycle.
	assign divisor = (state_q == ST_DIV_V) ? nc : nr;
	assign trial = {rem_q, dq_q[LEN_W-1]};
	assign diff = trial - {1'b0, divisor};
	assign q_bit = (trial >= {1'b0, divisor});
	assign rem_next = q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	assign dq_next = {dq_q[LEN_W-2:0], q_bit};
	assign div_done = (step_q == STEP_W'(LEN_W - 1));

	// Counter increments for the advance step.
	assign col_inc = col_q + CNT_W'(1);
	assign row_inc = row_q + CNT_W'(1);

	// Sequencer and traversal state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= bgt_pkg::PH_BACK_FRONT;
			row_q <= '0;
			col_q <= '0;
			outer_q <= OUTER_RST;
			inner_q <= INNER_RST;
			finished_q <= 1'b0;
			vert_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						step_q <= '0;
						if (req.restart) begin
							phase_q <= bgt_pkg::PH_BACK_FRONT;
							row_q <= '0;
							col_q <= '0;
							outer_q <= neg_hw;
							inner_q <= neg_hl;
							finished_q <= 1'b0;
							state_q <= ST_DIV_V;
						end else if (!finished_q) begin
							state_q <= ST_DIV_V;
						end
					end
				end
				ST_DIV_V: begin
					step_q <= div_done ? '0 : step_q + STEP_W'(1);
					if (div_done) begin
						state_q <= ST_DIV_H;
					end
				end
				ST_DIV_H: begin
					step_q <= div_done ? '0 : step_q + STEP_W'(1);
					if (div_done) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					vert_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (vtx_acc) begin
						vert_q <= vert_q + bgt_pkg::VERT_W'(1);
						if (last_vert) begin
							state_q <= ST_IDLE;
							// Advance to the next cell.
							if (col_inc >= nc) begin
								col_q <= '0;
								if (row_inc >= nr) begin
									row_q <= '0;
									outer_q <= neg_hw;
									inner_q <= neg_hl;
									unique case (phase_q)
										bgt_pkg::PH_BACK_FRONT: begin
											phase_q <= bgt_pkg::PH_TOP_BOTTOM;
										end
										bgt_pkg::PH_TOP_BOTTOM: begin
											phase_q <= bgt_pkg::PH_LEFT_RIGHT;
											inner_q <= neg_hw;
										end
										default: begin
											phase_q <= bgt_pkg::PH_BACK_FRONT;
											finished_q <= 1'b1;
										end
									endcase
								end else begin
									row_q <= row_inc;
									outer_q <= outer_q + hr_q;
									inner_q <= (phase_q == bgt_pkg::PH_LEFT_RIGHT) ?
										neg_hw : neg_hl;
								end
							end else begin
								col_q <= col_inc;
								inner_q <= inner_q +
									((phase_q == bgt_pkg::PH_LEFT_RIGHT) ? hr_q : vr_q);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath, step results and cell corners.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			dq_q <= box_length_q;
			rem_q <= '0;
		end else if (state_q == ST_DIV_V && div_done) begin
			vr_q <= CW'(dq_next);
			dq_q <= box_width_q;
			rem_q <= '0;
		end else if (state_q == ST_DIV_H && div_done) begin
			hr_q <= CW'(dq_next);
		end else if (state_q == ST_DIV_V || state_q == ST_DIV_H) begin
			dq_q <= dq_next;
			rem_q <= rem_next;
		end

		if (state_q == ST_SETUP) begin
			last_q <= (phase_q == bgt_pkg::PH_LEFT_RIGHT) && (row_inc >= nr) &&
				(col_inc >= nc);
			case (phase_q)
				bgt_pkg::PH_BACK_FRONT: begin
					lo_q[0] <= inner_q;
					hi_q[0] <= inner_q + vr_q;
					lo_q[1] <= outer_q;
					hi_q[1] <= outer_q + hr_q;
					lo_q[2] <= neg_hw;
					hi_q[2] <= hw;
				end
				bgt_pkg::PH_TOP_BOTTOM: begin
					lo_q[0] <= inner_q;
					hi_q[0] <= inner_q + vr_q;
					lo_q[1] <= hw;
					hi_q[1] <= neg_hw;
					lo_q[2] <= outer_q;
					hi_q[2] <= outer_q + hr_q;
				end
				default: begin
					lo_q[0] <= hl;
					hi_q[0] <= neg_hl;
					lo_q[1] <= outer_q;
					hi_q[1] <= outer_q + hr_q;
					lo_q[2] <= inner_q;
					hi_q[2] <= inner_q + hr_q;
				end
			endcase
		end
	end

	// Vertex output: pick low or high per axis from the corner table.
	assign corner = bgt_pkg::corner_sel(phase_q, vert_q);
	assign sel_x = corner[2] ? hi_q[0] : lo_q[0];
	assign sel_y = corner[1] ? hi_q[1] : lo_q[1];
	assign sel_z = corner[0] ? hi_q[2] : lo_q[2];

	assign vtx.valid = (state_q == ST_EMIT);
	assign vtx.vx = bgt_pkg::OUT_W'($signed(sel_x));
	assign vtx.vy = bgt_pkg::OUT_W'($signed(sel_y));
	assign vtx.vz = bgt_pkg::OUT_W'($signed(sel_z));
	assign vtx.cell_end = last_vert;
	assign vtx.box_end = last_vert & last_q;

endmodule
